FILE: sv/teqs_pkg.sv
// ----------------------------------------------------------------------------
// teqs_pkg
// Shared types and constants of the timed event queue scheduler.
// ----------------------------------------------------------------------------
package teqs_pkg;

   localparam int DEPTH_DEF = 32;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_ADD    = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_INIT   = 3'd3,
      CMD_START  = 3'd4,
      CMD_ENABLE = 3'd5,
      CMD_DISABLE = 3'd6,
      CMD_NOP    = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_FIRED   = 3'd0,
      KIND_LATE    = 3'd1,
      KIND_QUEUED  = 3'd2,
      KIND_DROPPED = 3'd3,
      KIND_RM_FIRE = 3'd4,
      KIND_RM_SIL  = 3'd5,
      KIND_NOTFND  = 3'd6,
      KIND_DONE    = 3'd7
   } kind_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // latch request, set walk pointer
      OP_INIT,      // clear store, start free-stack refill
      OP_FLAGS,     // apply start/enable/disable
      OP_TICK_PRE,  // handle pending start
      OP_TICK_ADV,  // advance current time
      OP_RD_HEAD,   // read entry at head
      OP_RD_WALK,   // read entry at walk pointer
      OP_STEP,      // advance walk pointer
      OP_UNLINK,    // unlink walk pointer slot
      OP_INSERT,    // link new entry
      OP_REFILL     // one free-stack refill step
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       emit;
      kind_type   kind;
      logic       last;
      logic       zero_keys;
      logic       entry_keys;
   } cmd_bus_type;

   typedef struct packed {
      cmd_type cmd;
      logic    late;
      logic    full;
      logic    empty;
      logic    enabled;
      logic    due_now;     // entry read is due (head fire)
      logic    key_match;   // entry read matches keys
      logic    ins_here;    // entry read has due <= new due
      logic    walk_end;    // walk count exhausted
      logic    refill_done;
      logic    fire;
   } stat_bus_type;

endpackage

FILE: sv/teqs_if.sv
// ----------------------------------------------------------------------------
// teqs_req_if / teqs_rsp_if / teqs_csr_if
// Valid/ready channels of the scheduler.
// ----------------------------------------------------------------------------
interface teqs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] due_time;
   logic [15:0] key_a;
   logic [15:0] key_b;
   logic        search_from_back;
   logic        fire_on_removal;
   modport source(output valid, cmd, due_time, key_a, key_b, search_from_back,
                  fire_on_removal, input ready);
   modport sink(input valid, cmd, due_time, key_a, key_b, search_from_back,
                fire_on_removal, output ready);
   modport monitor(input valid, ready, cmd, due_time, key_a, key_b, search_from_back,
                   fire_on_removal);
endinterface

interface teqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] out_key_a;
   logic [15:0] out_key_b;
   logic [5:0]  queued_count;
   logic        last;
   modport source(output valid, kind, out_key_a, out_key_b, queued_count, last,
                  input ready);
   modport sink(input valid, kind, out_key_a, out_key_b, queued_count, last,
                output ready);
   modport monitor(input valid, ready, kind, out_key_a, out_key_b, queued_count, last);
endinterface

interface teqs_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] timer_period;
   modport source(output valid, timer_period, input ready);
   modport sink(input valid, timer_period, output ready);
   modport monitor(input valid, ready, timer_period);
endinterface

FILE: sv/timed_event_queue_scheduler.sv
// One word at a time: the next is taken only when the list walk for the last is done.
// Reset: synchronous; a free-stack fill follows reset and each initialize word,
// during which no word is taken (register writes still are).
// ----------------------------------------------------------------------------
// timed_event_queue_scheduler
// Sorted timer event queue with free-slot stack and keyed removal.
// ----------------------------------------------------------------------------
module timed_event_queue_scheduler
   import teqs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   teqs_req_if.sink  req,
   teqs_rsp_if.source rsp,
   teqs_csr_if.sink  csr
);
   cmd_bus_type  ctl;
   stat_bus_type st;
   logic [15:0]  period_ff;

   // hold timer period register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) period_ff <= 16'd1;
      else if (csr.valid) period_ff <= csr.timer_period;
   end

   teqs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .st(st), .ctl(ctl),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
   );

   teqs_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .st(st),
      .req_cmd(req.cmd), .req_due_time(req.due_time), .req_key_a(req.key_a),
      .req_key_b(req.key_b), .req_search_from_back(req.search_from_back),
      .req_fire_on_removal(req.fire_on_removal), .period(period_ff),
      .rsp_kind(rsp.kind), .rsp_out_key_a(rsp.out_key_a),
      .rsp_out_key_b(rsp.out_key_b), .rsp_queued_count(rsp.queued_count),
      .rsp_last(rsp.last)
   );
endmodule

FILE: sv/teqs_datapath.sv
// ----------------------------------------------------------------------------
// teqs_datapath
// Event store, linked list, free stack, time and result word register.
// ----------------------------------------------------------------------------
module teqs_datapath
   import teqs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_bus_type  ctl,
   output stat_bus_type st,
   input  logic [2:0]   req_cmd,
   input  logic [31:0]  req_due_time,
   input  logic [15:0]  req_key_a,
   input  logic [15:0]  req_key_b,
   input  logic         req_search_from_back,
   input  logic         req_fire_on_removal,
   input  logic [15:0]  period,
   output logic [2:0]   rsp_kind,
   output logic [15:0]  rsp_out_key_a,
   output logic [15:0]  rsp_out_key_b,
   output logic [5:0]   rsp_queued_count,
   output logic         rsp_last
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // memories
   logic [31:0]   due_mem   [DEPTH];
   logic [15:0]   ka_mem    [DEPTH];
   logic [15:0]   kb_mem    [DEPTH];
   logic [AW-1:0] fwd_mem   [DEPTH];   // toward front
   logic [AW-1:0] bwd_mem   [DEPTH];   // toward back
   logic [AW-1:0] free_mem  [DEPTH];

   logic [31:0]   time_ff, time_in;
   logic          en_ff, pend_ff;
   logic [CW-1:0] count_ff, top_ff, walk_cnt_ff, refill_ff;
   logic [AW-1:0] head_ff, tail_ff, walk_ff;
   logic [2:0]    cmd_ff;
   logic [31:0]   due_ff;
   logic [15:0]   ka_ff, kb_ff;
   logic          back_ff, fire_ff;
   logic [31:0]   rd_due_ff;
   logic [15:0]   rd_ka_ff, rd_kb_ff;
   logic [AW-1:0] rd_fwd_ff, rd_bwd_ff, rd_slot_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] free_top_slot;

   // read address of the entry memories
   always_comb begin
      rd_addr = (ctl.op == OP_RD_HEAD) ? head_ff : walk_ff;
   end
   assign free_top_slot = free_mem[AW'(top_ff - CW'(1))];

   // status toward the controller
   always_comb begin
      st.cmd         = cmd_type'(cmd_ff);
      st.late        = due_ff < time_ff;
      st.full        = count_ff >= CW'(DEPTH);
      st.empty       = count_ff == '0;
      st.enabled     = en_ff;
      st.due_now     = !(time_ff < rd_due_ff);
      st.key_match   = (rd_ka_ff == ka_ff) && (rd_kb_ff == kb_ff);
      st.ins_here    = due_ff >= rd_due_ff;
      st.walk_end    = walk_cnt_ff == count_ff;
      st.refill_done = refill_ff == CW'(DEPTH);
      st.fire        = fire_ff;
   end

   assign time_in = time_ff + {16'd0, period};

   // registered entry read
   always_ff @(posedge clock) begin
      if (ctl.op == OP_RD_HEAD || ctl.op == OP_RD_WALK) begin
         rd_due_ff  <= due_mem[rd_addr];
         rd_ka_ff   <= ka_mem[rd_addr];
         rd_kb_ff   <= kb_mem[rd_addr];
         rd_fwd_ff  <= fwd_mem[rd_addr];
         rd_bwd_ff  <= bwd_mem[rd_addr];
         rd_slot_ff <= rd_addr;
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (ctl.op == OP_LOAD) begin
         cmd_ff  <= req_cmd;
         due_ff  <= req_due_time;
         ka_ff   <= req_key_a;
         kb_ff   <= req_key_b;
         back_ff <= req_search_from_back;
         fire_ff <= req_fire_on_removal;
      end
   end

   // list, free stack and time update
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff     <= '0;
         en_ff       <= 1'b0;
         pend_ff     <= 1'b0;
         count_ff    <= '0;
         top_ff      <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         walk_ff     <= '0;
         walk_cnt_ff <= '0;
         refill_ff   <= '0;
      end else begin
         case (ctl.op)
            OP_LOAD: begin
               walk_ff     <= (req_cmd == CMD_REMOVE && req_search_from_back) ||
                              req_cmd == CMD_ADD ? tail_ff : head_ff;
               walk_cnt_ff <= '0;
            end
            OP_INIT: begin
               time_ff   <= '0;
               en_ff     <= 1'b0;
               pend_ff   <= 1'b0;
               count_ff  <= '0;
               head_ff   <= '0;
               tail_ff   <= '0;
               top_ff    <= '0;
               refill_ff <= '0;
            end
            OP_REFILL: begin
               // push slots DEPTH-1 down to 0 so slot 0 pops first
               free_mem[AW'(refill_ff)] <= AW'(CW'(DEPTH - 1) - refill_ff);
               refill_ff <= refill_ff + CW'(1);
               top_ff    <= top_ff + CW'(1);
            end
            OP_FLAGS: begin
               case (cmd_ff)
                  CMD_START: begin
                     en_ff   <= 1'b1;
                     pend_ff <= 1'b1;
                  end
                  CMD_ENABLE:  en_ff <= 1'b1;
                  CMD_DISABLE: en_ff <= 1'b0;
                  default: ;
               endcase
            end
            OP_TICK_PRE: begin
               if (pend_ff) begin
                  pend_ff <= 1'b0;
                  time_ff <= '0;
               end
            end
            OP_TICK_ADV: time_ff <= time_in;
            OP_STEP: begin
               walk_ff     <= (cmd_ff == CMD_ADD || back_ff) ? rd_fwd_ff : rd_bwd_ff;
               walk_cnt_ff <= walk_cnt_ff + CW'(1);
            end
            OP_UNLINK: begin
               if (count_ff > CW'(1)) begin
                  if (rd_slot_ff == head_ff) begin
                     head_ff <= rd_bwd_ff;
                     fwd_mem[rd_bwd_ff] <= rd_bwd_ff;
                  end else if (rd_slot_ff == tail_ff) begin
                     tail_ff <= rd_fwd_ff;
                     bwd_mem[rd_fwd_ff] <= rd_fwd_ff;
                  end else begin
                     bwd_mem[rd_fwd_ff] <= rd_bwd_ff;
                     fwd_mem[rd_bwd_ff] <= rd_fwd_ff;
                  end
               end
               free_mem[AW'(top_ff)] <= rd_slot_ff;
               top_ff   <= top_ff + CW'(1);
               count_ff <= count_ff - CW'(1);
            end
            OP_INSERT: begin
               // walk ended on a held entry (<=), ran past the head, or the store was empty
               due_mem[free_top_slot] <= due_ff;
               ka_mem[free_top_slot]  <= ka_ff;
               kb_mem[free_top_slot]  <= kb_ff;
               top_ff   <= top_ff - CW'(1);
               count_ff <= count_ff + CW'(1);
               if (count_ff == '0) begin
                  fwd_mem[free_top_slot] <= free_top_slot;
                  bwd_mem[free_top_slot] <= free_top_slot;
                  head_ff <= free_top_slot;
                  tail_ff <= free_top_slot;
               end else if (!st.walk_end) begin
                  fwd_mem[free_top_slot] <= rd_slot_ff;
                  if (rd_slot_ff == tail_ff) begin
                     bwd_mem[free_top_slot] <= free_top_slot;
                     tail_ff <= free_top_slot;
                  end else begin
                     bwd_mem[free_top_slot] <= rd_bwd_ff;
                     fwd_mem[rd_bwd_ff] <= free_top_slot;
                  end
                  bwd_mem[rd_slot_ff] <= free_top_slot;
               end else begin
                  bwd_mem[free_top_slot] <= head_ff;
                  fwd_mem[free_top_slot] <= free_top_slot;
                  fwd_mem[head_ff] <= free_top_slot;
                  head_ff <= free_top_slot;
               end
            end
            default: ;
         endcase
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_kind  <= ctl.kind;
         rsp_last  <= ctl.last;
         if (ctl.zero_keys) begin
            rsp_out_key_a <= '0;
            rsp_out_key_b <= '0;
         end else if (ctl.entry_keys) begin
            rsp_out_key_a <= rd_ka_ff;
            rsp_out_key_b <= rd_kb_ff;
         end else begin
            rsp_out_key_a <= ka_ff;
            rsp_out_key_b <= kb_ff;
         end
         case (ctl.kind)
            KIND_FIRED, KIND_RM_FIRE, KIND_RM_SIL:
               rsp_queued_count <= 6'(count_ff - CW'(1));
            KIND_QUEUED: rsp_queued_count <= 6'(count_ff + CW'(1));
            KIND_DONE: rsp_queued_count <= (cmd_ff == CMD_INIT) ? 6'd0 : 6'(count_ff);
            default: rsp_queued_count <= 6'(count_ff);
         endcase
      end
   end

   // free stack never overflows the memory
   assert property (@(posedge clock) disable iff (reset) top_ff <= CW'(DEPTH))
      else $error("free stack overflow");
   assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_INSERT |-> !st.full)
      else $error("insert into full store");
   assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_UNLINK |-> !st.empty)
      else $error("unlink from empty store");
endmodule

FILE: sv/teqs_ctrl.sv
// ----------------------------------------------------------------------------
// teqs_ctrl
// Sequencer of the scheduler: decodes one word and steps the datapath.
// ----------------------------------------------------------------------------
module teqs_ctrl
   import teqs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  stat_bus_type st,
   output cmd_bus_type  ctl,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready
);
   typedef enum logic [3:0] {
      S_REFILL, S_IDLE, S_DECODE, S_TICK_RD, S_TICK_CHK, S_WALK_RD, S_WALK_CHK,
      S_OUT, S_NEXT
   } state_type;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;
   logic      more_ff, more_in;   // tick continues after this word
   logic      adv_ff, adv_in;

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff;
      more_in  = more_ff;
      adv_in   = adv_ff;
      ctl      = '{op: OP_NONE, emit: 1'b0, kind: KIND_DONE, last: 1'b1,
                   zero_keys: 1'b1, entry_keys: 1'b0};
      req_ready = 1'b0;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      case (state_ff)
         S_REFILL: begin
            if (st.refill_done) state_in = S_IDLE;
            else ctl.op = OP_REFILL;
         end
         S_IDLE: begin
            req_ready = !vld_ff || rsp_ready;
            if (req_valid && req_ready) begin
               ctl.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (st.cmd)
               CMD_TICK: begin
                  ctl.op   = OP_TICK_PRE;
                  state_in = st.enabled ? S_TICK_RD : S_OUT;
                  adv_in   = 1'b0;
               end
               CMD_ADD: begin
                  ctl.kind = st.late ? KIND_LATE : (st.full ? KIND_DROPPED : KIND_QUEUED);
                  ctl.zero_keys = 1'b0;
                  if (st.late || st.full) begin
                     ctl.emit = 1'b1;
                     vld_in   = 1'b1;
                     state_in = S_IDLE;
                  end else if (st.empty || st.walk_end) begin
                     ctl.op = OP_INSERT; ctl.emit = 1'b1; vld_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_WALK_RD;
                  end
               end
               CMD_REMOVE: begin
                  if (st.walk_end) begin
                     ctl.emit = 1'b1; ctl.kind = KIND_NOTFND; ctl.zero_keys = 1'b0;
                     vld_in = 1'b1; state_in = S_IDLE;
                  end else state_in = S_WALK_RD;
               end
               CMD_INIT: begin
                  ctl.op = OP_INIT; ctl.emit = 1'b1; vld_in = 1'b1;
                  state_in = S_NEXT;
               end
               default: begin
                  ctl.op = OP_FLAGS; ctl.emit = 1'b1; vld_in = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_TICK_RD: begin
            if (st.empty) begin
               ctl.op = OP_TICK_ADV; state_in = S_OUT;
            end else begin
               ctl.op = OP_RD_HEAD; state_in = S_TICK_CHK;
            end
         end
         S_TICK_CHK: begin
            if (!st.due_now) begin
               ctl.op = OP_TICK_ADV; state_in = S_OUT;
            end else if (!vld_ff || rsp_ready) begin
               ctl.op = OP_UNLINK; ctl.emit = 1'b1; ctl.kind = KIND_FIRED;
               ctl.last = 1'b0; ctl.zero_keys = 1'b0; ctl.entry_keys = 1'b1;
               vld_in = 1'b1; state_in = S_TICK_RD;
            end
         end
         S_WALK_RD: begin
            ctl.op = OP_RD_WALK; state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (st.cmd == CMD_ADD) begin
               if (st.ins_here) begin
                  ctl.op = OP_INSERT; ctl.emit = 1'b1; ctl.kind = KIND_QUEUED;
                  ctl.zero_keys = 1'b0; vld_in = 1'b1; state_in = S_NEXT;
               end else begin
                  ctl.op = OP_STEP; state_in = S_NEXT; adv_in = 1'b1;
               end
            end else if (st.key_match) begin
               ctl.op = OP_UNLINK; ctl.emit = 1'b1; ctl.zero_keys = 1'b0;
               ctl.kind = st.fire ? KIND_RM_FIRE : KIND_RM_SIL;
               vld_in = 1'b1; state_in = S_NEXT;
            end else begin
               ctl.op = OP_STEP; state_in = S_NEXT; adv_in = 1'b1;
            end
         end
         S_NEXT: begin
            // after an initialize word, start the refill; after a step, decide on walk end; otherwise finish
            if (st.cmd == CMD_INIT) state_in = S_REFILL;
            else if (!adv_ff) state_in = S_IDLE;
            else begin
               adv_in = 1'b0;
               if (!st.walk_end) state_in = S_WALK_RD;
               else if (st.cmd == CMD_ADD) begin
                  ctl.op = OP_INSERT; ctl.emit = 1'b1; ctl.kind = KIND_QUEUED;
                  ctl.zero_keys = 1'b0; vld_in = 1'b1; state_in = S_IDLE;
               end else begin
                  ctl.emit = 1'b1; ctl.kind = KIND_NOTFND; ctl.zero_keys = 1'b0;
                  vld_in = 1'b1; state_in = S_IDLE;
               end
            end
         end
         S_OUT: begin
            if (!vld_ff || rsp_ready) begin
               ctl.emit = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // hold emission until the output register is free
      if (ctl.emit && vld_ff && !rsp_ready && state_ff != S_TICK_CHK &&
          state_ff != S_OUT) begin
         ctl = '{op: OP_NONE, emit: 1'b0, kind: KIND_DONE, last: 1'b1,
                 zero_keys: 1'b1, entry_keys: 1'b0};
         state_in = state_ff;
         vld_in   = vld_ff;
         adv_in   = adv_ff;
      end
      more_in = (state_in == S_TICK_RD);
   end

   assign rsp_valid = vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_REFILL;
         vld_ff   <= 1'b0;
         more_ff  <= 1'b0;
         adv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         more_ff  <= more_in;
         adv_ff   <= adv_in;
      end
   end

   // a word is never overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp_ready |-> !ctl.emit)
      else $error("result word overwritten");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("request taken outside idle");
   assert property (@(posedge clock) disable iff (reset)
      more_ff |-> !req_ready)
      else $error("request taken during tick");
endmodule

FILE: sim/teqs_scoreboard.sv
// ----------------------------------------------------------------------------
// teqs_scoreboard
// Watches the request, result and register channels of the scheduler, keeps
// its own sorted event list and timer state, and compares every result word
// field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module teqs_scoreboard
   import teqs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   teqs_req_if.monitor req_mon,
   teqs_rsp_if.monitor rsp_mon,
   teqs_csr_if.monitor csr_mon,
   output int         fail_count,
   output int         pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = DEPTH_DEF;

   typedef struct {
      kind_type    kind;
      logic [15:0] key_a;
      logic [15:0] key_b;
      logic [5:0]  count;
      logic        last;
   } result_word;

   typedef struct {
      logic [31:0] due;
      logic [15:0] key_a;
      logic [15:0] key_b;
   } event_entry;

   // the list is held in sorted order, front at index 0
   event_entry  queue_list[$];
   result_word  expected_words[$];
   logic [15:0] period;
   logic [31:0] now;
   logic        running;
   logic        restart;

   function automatic void push_word(kind_type k, logic [15:0] a, logic [15:0] b,
                                     logic l);
      result_word w;
      w.kind = k;
      w.key_a = a;
      w.key_b = b;
      w.count = 6'(queue_list.size());
      w.last = l;
      expected_words.push_back(w);
   endfunction

   // work out the result words that one request word causes
   function automatic void schedule_request(cmd_type c, logic [31:0] due,
                                            logic [15:0] a, logic [15:0] b,
                                            logic from_back, logic fire);
      int pos;
      event_entry e;
      case (c)
         CMD_TICK: begin
            if (restart) begin
               restart = 1'b0;
               now = '0;
            end
            if (running) begin
               while (queue_list.size() > 0 && now >= queue_list[0].due) begin
                  e = queue_list.pop_front();
                  push_word(KIND_FIRED, e.key_a, e.key_b, 1'b0);
               end
               now = now + 32'(period);
            end
            push_word(KIND_DONE, '0, '0, 1'b1);
         end
         CMD_ADD: begin
            if (due < now) begin
               push_word(KIND_LATE, a, b, 1'b1);
            end else if (queue_list.size() >= SLOTS) begin
               push_word(KIND_DROPPED, a, b, 1'b1);
            end else begin
               // insert after the last entry due at or before the new one
               pos = queue_list.size();
               while (pos > 0 && due < queue_list[pos-1].due) pos--;
               e.due = due;
               e.key_a = a;
               e.key_b = b;
               queue_list.insert(pos, e);
               push_word(KIND_QUEUED, a, b, 1'b1);
            end
         end
         CMD_REMOVE: begin
            pos = -1;
            if (from_back) begin
               for (int i = queue_list.size() - 1; i >= 0; i--)
                  if (pos < 0 && queue_list[i].key_a == a && queue_list[i].key_b == b)
                     pos = i;
            end else begin
               for (int i = 0; i < queue_list.size(); i++)
                  if (pos < 0 && queue_list[i].key_a == a && queue_list[i].key_b == b)
                     pos = i;
            end
            if (pos >= 0) begin
               queue_list.delete(pos);
               push_word(fire ? KIND_RM_FIRE : KIND_RM_SIL, a, b, 1'b1);
            end else begin
               push_word(KIND_NOTFND, a, b, 1'b1);
            end
         end
         CMD_INIT: begin
            running = 1'b0;
            restart = 1'b0;
            now = '0;
            queue_list.delete();
            push_word(KIND_DONE, '0, '0, 1'b1);
         end
         CMD_START: begin
            running = 1'b1;
            restart = 1'b1;
            push_word(KIND_DONE, '0, '0, 1'b1);
         end
         CMD_ENABLE: begin
            running = 1'b1;
            push_word(KIND_DONE, '0, '0, 1'b1);
         end
         CMD_DISABLE: begin
            running = 1'b0;
            push_word(KIND_DONE, '0, '0, 1'b1);
         end
         default: push_word(KIND_DONE, '0, '0, 1'b1);
      endcase
   endfunction

   always @(posedge clock) begin
      result_word w;
      int errs;
      errs = 0;
      if (reset) begin
         period = 16'd1;
         now = '0;
         running = 1'b0;
         restart = 1'b0;
         queue_list.delete();
         expected_words.delete();
         fail_count <= 0;
         pending_words <= 0;
      end else begin
         // track the timer period
         if (csr_mon.valid && csr_mon.ready) period = csr_mon.timer_period;
         // predict from each accepted request word
         if (req_mon.valid && req_mon.ready)
            schedule_request(cmd_type'(req_mon.cmd), req_mon.due_time, req_mon.key_a,
                             req_mon.key_b, req_mon.search_from_back,
                             req_mon.fire_on_removal);
         // compare each accepted result word
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word kind=%0d", rsp_mon.kind);
               errs = errs + 1;
            end else begin
               w = expected_words.pop_front();
               if (rsp_mon.kind !== w.kind) begin
                  $error("kind: expected %0d, got %0d", w.kind, rsp_mon.kind);
                  errs = errs + 1;
               end
               if (rsp_mon.out_key_a !== w.key_a) begin
                  $error("out_key_a: expected %0h, got %0h", w.key_a, rsp_mon.out_key_a);
                  errs = errs + 1;
               end
               if (rsp_mon.out_key_b !== w.key_b) begin
                  $error("out_key_b: expected %0h, got %0h", w.key_b, rsp_mon.out_key_b);
                  errs = errs + 1;
               end
               if (rsp_mon.queued_count !== w.count) begin
                  $error("queued_count: expected %0d, got %0d", w.count,
                         rsp_mon.queued_count);
                  errs = errs + 1;
               end
               if (rsp_mon.last !== w.last) begin
                  $error("last: expected %0d, got %0d", w.last, rsp_mon.last);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_words <= expected_words.size();
      end
   end

endmodule

FILE: sim/timed_event_queue_scheduler_test.sv
// ----------------------------------------------------------------------------
// timed_event_queue_scheduler_test
// Drives directed and random command words and timer period writes into the
// scheduler with random idle bursts on both channels; the scoreboard checks
// every result word and the top gives the verdict.
// ----------------------------------------------------------------------------
module timed_event_queue_scheduler_test;
   import teqs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS = 360;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   fail_count;
   int   pending_words;
   int   idle_cycles = 0;
   int   rsp_hold = 0;

   teqs_req_if req_ch();
   teqs_rsp_if rsp_ch();
   teqs_csr_if csr_ch();

   timed_event_queue_scheduler dut (.clock(clock), .reset(reset), .req(req_ch.sink),
                                    .rsp(rsp_ch.source), .csr(csr_ch.sink));

   teqs_scoreboard checker_unit (.clock(clock), .reset(reset), .req_mon(req_ch.monitor),
                                 .rsp_mon(rsp_ch.monitor), .csr_mon(csr_ch.monitor),
                                 .fail_count(fail_count), .pending_words(pending_words));

   always #6 clock = ~clock;

   // stall the result side in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ch.ready <= (rsp_hold == 1);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_hold <= $urandom_range(1, 12);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timed_event_queue_scheduler_test: done, errors");
         $finish;
      end
   end

   // valid stays high into the next word unless an idle burst comes between
   task automatic send_word(cmd_type c, logic [31:0] due, logic [15:0] a,
                            logic [15:0] b, logic from_back, logic fire);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= c;
      req_ch.due_time <= due;
      req_ch.key_a <= a;
      req_ch.key_b <= b;
      req_ch.search_from_back <= from_back;
      req_ch.fire_on_removal <= fire;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // write the timer period once all results are back and the block has settled
   task automatic write_period(logic [15:0] p);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.timer_period <= p;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_phase(int words, int key_span, int due_span);
      int r;
      logic [31:0] due;
      for (int i = 0; i < words; i++) begin
         r = $urandom_range(0, 99);
         due = (due_span == 0) ? $urandom() : 32'($urandom_range(0, due_span));
         if (r < 45)
            send_word(CMD_ADD, due, 16'($urandom_range(0, key_span)),
                      16'($urandom_range(0, key_span)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         else if (r < 65)
            send_word(CMD_REMOVE, $urandom(), 16'($urandom_range(0, key_span)),
                      16'($urandom_range(0, key_span)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         else if (r < 90)
            send_word(CMD_TICK, $urandom(), 16'($urandom()), 16'($urandom()),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else
            send_word(cmd_type'($urandom_range(3, 7)), $urandom(), 16'($urandom()),
                      16'($urandom()), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_TICK;
      req_ch.due_time = '0;
      req_ch.key_a = '0;
      req_ch.key_b = '0;
      req_ch.search_from_back = 1'b0;
      req_ch.fire_on_removal = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.timer_period = 16'd1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: fill past full, equal times, both remove ends, late add
      send_word(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_START, '0, '0, '0, 1'b0, 1'b0);
      for (int i = 0; i < 33; i++)
         send_word(CMD_ADD, (i == 32) ? 32'hFFFF_FFFF : 32'(i % 3), 16'(i % 4),
                   16'hFFFF, 1'b0, 1'b0);
      send_word(CMD_REMOVE, '0, 16'd1, 16'hFFFF, 1'b1, 1'b1);
      send_word(CMD_REMOVE, '0, 16'd2, 16'hFFFF, 1'b0, 1'b0);
      send_word(CMD_REMOVE, '0, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
      send_word(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_ADD, '0, 16'hAAAA, 16'h5555, 1'b1, 1'b0);
      send_word(CMD_DISABLE, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_NOP, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_INIT, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_REMOVE, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_ENABLE, '0, '0, '0, 1'b0, 1'b0);

      // random phases under several periods, extremes among them
      write_period(16'hFFFF);
      random_phase(RANDOM_WORDS / 4, 3, 0);
      write_period(16'd1);
      send_word(CMD_INIT, '0, '0, '0, 1'b0, 1'b0);
      send_word(CMD_ENABLE, '0, '0, '0, 1'b0, 1'b0);
      random_phase(RANDOM_WORDS / 4, 7, 40);
      write_period(16'd5);
      random_phase(RANDOM_WORDS / 4, 3, 200);
      write_period(16'($urandom_range(2, 30)));
      quiet = 1'b1;
      random_phase(RANDOM_WORDS / 4, 5, 120);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("timed_event_queue_scheduler_test: done, clean");
      else
         $display("timed_event_queue_scheduler_test: done, errors");
      $finish;
   end

endmodule

FILE: files.f
sv/teqs_pkg.sv
sv/teqs_if.sv
sv/teqs_datapath.sv
sv/teqs_ctrl.sv
sv/timed_event_queue_scheduler.sv
sim/teqs_scoreboard.sv
sim/timed_event_queue_scheduler_test.sv
